### rtl/core/bafit_pkg.sv
// Package for the best-fit buddy allocator: sizes, table entry, payload
// structs, controller states and command/status bundles. No dependencies.
package bafit_pkg;

    localparam int TOP_BLOCK_BYTES = 131072;
    localparam int NUM_TOP_BLOCKS  = 32;
    localparam int HEADER_BYTES    = 40;
    localparam int MIN_BLOCK_BYTES = 64;
    localparam int MAX_REQUEST     = 100000000;

    localparam int SLOTS_PER_TOP = TOP_BLOCK_BYTES / MIN_BLOCK_BYTES;
    localparam int POOL_SLOTS    = NUM_TOP_BLOCKS * SLOTS_PER_TOP;
    localparam int SLOT_W        = $clog2(POOL_SLOTS);
    localparam int MIN_SHIFT     = $clog2(MIN_BLOCK_BYTES);
    localparam int TOP_ORDER     = $clog2(SLOTS_PER_TOP);
    localparam int ORD_W         = 4;
    localparam int BYTES_W       = $clog2(TOP_BLOCK_BYTES) + 1;
    localparam int ENTRY_W       = ORD_W + 2;

    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [ORD_W-1:0]   t_ord;
    typedef logic [BYTES_W-1:0] t_bytes;

    typedef struct packed {
        logic head;
        logic free;
        t_ord ord;
    } t_entry;

    typedef enum logic [2:0] {
        RS_OK        = 3'd0,
        RS_BAD_SIZE  = 3'd1,
        RS_NO_FIT    = 3'd2,
        RS_TOO_LARGE = 3'd3,
        RS_FREE_IGN  = 3'd4
    } t_status;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [26:0] request_size;
        logic [21:0] address;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [21:0] granted_address;
        logic [16:0] free_block_count;
        logic [21:0] free_byte_count;
        logic [16:0] total_block_count;
        logic [21:0] header_byte_count;
    } t_out;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_SRCH_ADDR, S_SRCH_EVAL, S_SRCH_END, S_SPLIT,
        S_ALLOC_FIN, S_FREE_ADDR, S_FREE_CHK, S_MERGE_ADDR, S_MERGE_CHK,
        S_FREE_FIN, S_DONE
    } t_state;

    typedef struct packed {
        logic    clr_step;
        logic    load;
        logic    rd_slot;
        logic    rd_buddy;
        logic    srch_eval;
        logic    split_step;
        logic    alloc_fin;
        logic    free_take;
        logic    merge_step;
        logic    free_fin;
        logic    st_load;
        t_status st_code;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic op_free;
        logic bad_size;
        logic too_large;
        logic free_bad;
        logic srch_last;
        logic found;
        logic split_more;
        logic entry_bad;
        logic ord_top;
        logic merge_ok;
        logic out_busy;
    } t_sts;

    function automatic t_bytes block_bytes(input t_ord ord);
        block_bytes = t_bytes'(MIN_BLOCK_BYTES) << ord;
    endfunction

endpackage

### rtl/core/bafit_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bafit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/bafit_ctrl.sv
// Controller state machine of the buddy allocator.
// Depends on bafit_pkg.
module bafit_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  bafit_pkg::t_sts i_sts,
    output bafit_pkg::t_cmd o_cmd,
    output logic           o_idle
);
    import bafit_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:      if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE:       if (i_valid) n_state = S_DECODE;
            S_DECODE: begin
                if (i_sts.op_free) begin
                    n_state = i_sts.free_bad ? S_DONE : S_FREE_ADDR;
                end else if (i_sts.bad_size || i_sts.too_large) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SRCH_ADDR;
                end
            end
            S_SRCH_ADDR:  n_state = S_SRCH_EVAL;
            S_SRCH_EVAL:  n_state = i_sts.srch_last ? S_SRCH_END : S_SRCH_ADDR;
            S_SRCH_END:   n_state = i_sts.found ? S_SPLIT : S_DONE;
            S_SPLIT:      if (!i_sts.split_more) n_state = S_ALLOC_FIN;
            S_ALLOC_FIN:  n_state = S_DONE;
            S_FREE_ADDR:  n_state = S_FREE_CHK;
            S_FREE_CHK:   n_state = i_sts.entry_bad ? S_DONE : S_MERGE_ADDR;
            S_MERGE_ADDR: n_state = i_sts.ord_top ? S_FREE_FIN : S_MERGE_CHK;
            S_MERGE_CHK:  n_state = i_sts.merge_ok ? S_MERGE_ADDR : S_FREE_FIN;
            S_FREE_FIN:   n_state = S_DONE;
            S_DONE:       if (!i_sts.out_busy) n_state = S_IDLE;
            default:      n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.st_code = RS_OK;
        o_idle = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_idle = 1'b1;
                o_cmd.load = i_valid;
            end
            S_DECODE: begin
                o_cmd.st_load = 1'b1;
                if (i_sts.op_free) begin
                    o_cmd.st_code = RS_FREE_IGN;
                end else if (i_sts.bad_size) begin
                    o_cmd.st_code = RS_BAD_SIZE;
                end else if (i_sts.too_large) begin
                    o_cmd.st_code = RS_TOO_LARGE;
                end else begin
                    o_cmd.st_code = RS_NO_FIT;
                end
            end
            S_SRCH_EVAL:  o_cmd.srch_eval = 1'b1;
            S_SPLIT:      o_cmd.split_step = i_sts.split_more;
            S_ALLOC_FIN: begin
                o_cmd.alloc_fin = 1'b1;
                o_cmd.st_load   = 1'b1;
                o_cmd.st_code   = RS_OK;
            end
            S_FREE_ADDR:  o_cmd.rd_slot = 1'b1;
            S_FREE_CHK:   o_cmd.free_take = !i_sts.entry_bad;
            S_MERGE_ADDR: o_cmd.rd_buddy = 1'b1;
            S_MERGE_CHK:  o_cmd.merge_step = i_sts.merge_ok;
            S_FREE_FIN: begin
                o_cmd.free_fin = 1'b1;
                o_cmd.st_load  = 1'b1;
                o_cmd.st_code  = RS_OK;
            end
            S_DONE:       o_cmd.out_load = !i_sts.out_busy;
            default:      o_cmd = '0;
        endcase
    end
endmodule

### rtl/core/bafit_dp.sv
// Datapath of the buddy allocator: block table, search, split and merge
// registers, counters and the result register. Depends on bafit_pkg, bafit_ram.
module bafit_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bafit_pkg::t_in  i_data,
    input  logic            i_stall,
    input  bafit_pkg::t_cmd i_cmd,
    output bafit_pkg::t_sts o_sts,
    output logic            o_valid,
    output bafit_pkg::t_out o_data
);
    import bafit_pkg::*;

    logic        r_op;
    logic [26:0] r_size;
    logic [21:0] r_addr;
    logic [16:0] r_idx;
    logic        r_found;
    t_slot       r_best;
    t_ord        r_best_ord;
    t_slot       r_slot;
    t_ord        r_ord;
    logic [16:0] r_fblk;
    logic [22:0] r_fbyte;
    logic [16:0] r_tblk;
    t_slot       r_clr;
    logic [2:0]  r_status;
    logic [21:0] r_granted;
    logic        r_ovalid;
    t_out        r_odata;

    t_entry      rd_e;
    logic [ENTRY_W-1:0] rd_raw;
    logic        we;
    t_slot       waddr;
    t_entry      wdata;
    t_slot       raddr;
    t_bytes      need;
    logic [21:0] start;
    logic [16:0] n_idx;
    t_slot       buddy;
    t_ord        dec_ord;
    logic        fits;

    assign rd_e    = t_entry'(rd_raw);
    assign need    = t_bytes'(r_size[BYTES_W-2:0]) + t_bytes'(HEADER_BYTES);
    assign start   = r_addr - 22'(HEADER_BYTES);
    assign n_idx   = r_idx + (rd_e.head ? (17'd1 << rd_e.ord) : 17'd1);
    assign buddy   = r_slot ^ (t_slot'(1) << r_ord);
    assign dec_ord = r_best_ord - t_ord'(1);
    assign fits    = rd_e.free && (block_bytes(rd_e.ord) >= need);

    assign o_sts.clr_last   = (r_clr == t_slot'(POOL_SLOTS - 1));
    assign o_sts.op_free    = (r_op == OP_FREE);
    assign o_sts.bad_size   = (r_size == '0) || (r_size > 27'(MAX_REQUEST));
    assign o_sts.too_large  = (r_size >= 27'(TOP_BLOCK_BYTES));
    assign o_sts.free_bad   = (r_addr < 22'(HEADER_BYTES)) || (start[MIN_SHIFT-1:0] != '0);
    assign o_sts.srch_last  = n_idx[SLOT_W];
    assign o_sts.found      = r_found;
    assign o_sts.split_more = (r_best_ord != '0) && (block_bytes(dec_ord) >= need);
    assign o_sts.entry_bad  = !rd_e.head || rd_e.free;
    assign o_sts.ord_top    = (r_ord >= t_ord'(TOP_ORDER));
    assign o_sts.merge_ok   = rd_e.head && rd_e.free && (rd_e.ord == r_ord);
    assign o_sts.out_busy   = r_ovalid && i_stall;

    always_comb begin
        we    = 1'b0;
        waddr = r_slot;
        wdata = '0;
        if (i_cmd.clr_step) begin
            we    = 1'b1;
            waddr = r_clr;
            if (r_clr[TOP_ORDER-1:0] == '0) begin
                wdata = '{head: 1'b1, free: 1'b1, ord: t_ord'(TOP_ORDER)};
            end
        end else if (i_cmd.split_step) begin
            we    = 1'b1;
            waddr = r_best + (t_slot'(1) << dec_ord);
            wdata = '{head: 1'b1, free: 1'b1, ord: dec_ord};
        end else if (i_cmd.alloc_fin) begin
            we    = 1'b1;
            waddr = r_best;
            wdata = '{head: 1'b1, free: 1'b0, ord: r_best_ord};
        end else if (i_cmd.merge_step) begin
            we    = 1'b1;
            waddr = (buddy < r_slot) ? r_slot : buddy;
        end else if (i_cmd.free_fin) begin
            we    = 1'b1;
            waddr = r_slot;
            wdata = '{head: 1'b1, free: 1'b1, ord: r_ord};
        end
    end

    always_comb begin
        if (i_cmd.rd_slot) begin
            raddr = start[MIN_SHIFT +: SLOT_W];
        end else if (i_cmd.rd_buddy) begin
            raddr = buddy;
        end else begin
            raddr = r_idx[SLOT_W-1:0];
        end
    end

    bafit_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(POOL_SLOTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_fblk   <= 17'(NUM_TOP_BLOCKS);
            r_tblk   <= 17'(NUM_TOP_BLOCKS);
            r_fbyte  <= 23'(NUM_TOP_BLOCKS * (TOP_BLOCK_BYTES - HEADER_BYTES));
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + t_slot'(1);
            if (i_cmd.load) begin
                r_op      <= i_data.op;
                r_size    <= i_data.request_size;
                r_addr    <= i_data.address;
                r_idx     <= '0;
                r_found   <= 1'b0;
                r_granted <= '0;
            end
            if (i_cmd.srch_eval) begin
                r_idx <= n_idx;
                if (rd_e.head && fits && (!r_found || rd_e.ord < r_best_ord)) begin
                    r_found    <= 1'b1;
                    r_best     <= r_idx[SLOT_W-1:0];
                    r_best_ord <= rd_e.ord;
                end
            end
            if (i_cmd.split_step) begin
                r_best_ord <= dec_ord;
                r_fblk     <= r_fblk + 17'd1;
                r_tblk     <= r_tblk + 17'd1;
                r_fbyte    <= r_fbyte - 23'(HEADER_BYTES);
            end
            if (i_cmd.alloc_fin) begin
                r_fblk    <= r_fblk - 17'd1;
                r_fbyte   <= r_fbyte - 23'(block_bytes(r_best_ord))
                             + 23'(HEADER_BYTES);
                r_granted <= 22'({r_best, {MIN_SHIFT{1'b0}}}) + 22'(HEADER_BYTES);
            end
            if (i_cmd.rd_slot) r_slot <= start[MIN_SHIFT +: SLOT_W];
            if (i_cmd.free_take) begin
                r_ord   <= rd_e.ord;
                r_fblk  <= r_fblk + 17'd1;
                r_fbyte <= r_fbyte + 23'(block_bytes(rd_e.ord)) - 23'(HEADER_BYTES);
            end
            if (i_cmd.merge_step) begin
                if (buddy < r_slot) r_slot <= buddy;
                r_ord   <= r_ord + t_ord'(1);
                r_fblk  <= r_fblk - 17'd1;
                r_tblk  <= r_tblk - 17'd1;
                r_fbyte <= r_fbyte + 23'(HEADER_BYTES);
            end
            if (i_cmd.st_load) r_status <= i_cmd.st_code;
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
                r_odata.status            <= r_status;
                r_odata.granted_address   <= r_granted;
                r_odata.free_block_count  <= r_fblk;
                r_odata.free_byte_count   <= r_fbyte[21:0];
                r_odata.total_block_count <= r_tblk;
                r_odata.header_byte_count <= 22'(r_tblk * 22'(HEADER_BYTES));
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
endmodule

### rtl/core/buddy_allocator_best_fit.sv
// Best-fit buddy allocator top level. Depends on bafit_pkg, bafit_ctrl, bafit_dp.
// One item at a time: the next input transfer comes no earlier than the cycle after the result
// loads; the table scan (one read per block, registered read port) sets alloc time.
// Reset: a clearing pass writes every entry of the block table; no input transfer meanwhile.
module buddy_allocator_best_fit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  bafit_pkg::t_in  i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output bafit_pkg::t_out o_data
);
    import bafit_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic idle;

    bafit_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_idle (idle)
    );

    bafit_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_data (i_data),
        .i_stall(i_stall),
        .i_cmd  (cmd),
        .o_sts  (sts),
        .o_valid(o_valid),
        .o_data (o_data)
    );

    assign o_stall = !idle;
endmodule

### tb/tb_buddy_allocator_best_fit_chk.sv
// Transfer monitor and predictor for the best-fit buddy allocator.
// Depends on bafit_pkg; reports the failure count and pending count to the top.
`timescale 1ns / 1ps

module tb_buddy_allocator_best_fit_chk
    import bafit_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_stall_in,
    input  t_in  i_data,
    input  logic o_valid,
    input  logic i_stall_out,
    input  t_out o_data,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct {
        logic    head;
        logic    free;
        int      ord;
    } t_slot_entry;

    t_slot_entry heads [POOL_SLOTS];
    longint      free_blocks;
    longint      free_bytes;
    longint      total_blocks;
    t_out        expected_q [$];

    function automatic longint blk_bytes(int ord);
        return longint'(MIN_BLOCK_BYTES) << ord;
    endfunction

    function automatic void pool_reset();
        for (int i = 0; i < POOL_SLOTS; i++) begin
            heads[i] = '{1'b0, 1'b0, 0};
        end
        for (int i = 0; i < NUM_TOP_BLOCKS; i++) begin
            heads[i * SLOTS_PER_TOP] = '{1'b1, 1'b1, TOP_ORDER};
        end
        free_blocks  = NUM_TOP_BLOCKS;
        total_blocks = NUM_TOP_BLOCKS;
        free_bytes   = longint'(NUM_TOP_BLOCKS) * (TOP_BLOCK_BYTES - HEADER_BYTES);
    endfunction

    function automatic t_status pool_alloc(longint size, output longint granted);
        longint need;
        longint best;
        longint right;
        int     best_ord;
        bit     found;
        int     i;
        need     = size + HEADER_BYTES;
        best     = 0;
        best_ord = 0;
        found    = 0;
        granted  = 0;
        i        = 0;
        if (size == 0 || size > MAX_REQUEST) return RS_BAD_SIZE;
        if (size >= TOP_BLOCK_BYTES) return RS_TOO_LARGE;
        while (i < POOL_SLOTS) begin
            if (!heads[i].head) begin
                i++;
            end else begin
                if (heads[i].free && blk_bytes(heads[i].ord) >= need &&
                    (!found || heads[i].ord < best_ord)) begin
                    found    = 1;
                    best     = i;
                    best_ord = heads[i].ord;
                end
                i += 1 << heads[i].ord;
            end
        end
        if (!found) return RS_NO_FIT;
        while (best_ord > 0 && blk_bytes(best_ord - 1) >= need) begin
            best_ord--;
            right = best + (longint'(1) << best_ord);
            if (right < POOL_SLOTS) heads[right] = '{1'b1, 1'b1, best_ord};
            free_blocks++;
            free_bytes -= HEADER_BYTES;
            total_blocks++;
        end
        heads[best] = '{1'b1, 1'b0, best_ord};
        free_blocks--;
        free_bytes -= blk_bytes(best_ord) - HEADER_BYTES;
        granted = best * MIN_BLOCK_BYTES + HEADER_BYTES;
        return RS_OK;
    endfunction

    function automatic t_status pool_free(longint addr);
        longint start;
        longint slot;
        longint buddy;
        int     ord;
        if (addr < HEADER_BYTES) return RS_FREE_IGN;
        start = addr - HEADER_BYTES;
        if (start % MIN_BLOCK_BYTES != 0) return RS_FREE_IGN;
        slot = start / MIN_BLOCK_BYTES;
        if (slot >= POOL_SLOTS) return RS_FREE_IGN;
        if (!heads[slot].head || heads[slot].free) return RS_FREE_IGN;
        ord = heads[slot].ord;
        free_blocks++;
        free_bytes += blk_bytes(ord) - HEADER_BYTES;
        while (ord < TOP_ORDER) begin
            buddy = slot ^ (longint'(1) << ord);
            if (buddy >= POOL_SLOTS) break;
            if (!heads[buddy].head || !heads[buddy].free || heads[buddy].ord != ord) break;
            if (buddy < slot) begin
                heads[slot] = '{1'b0, 1'b0, 0};
                slot = buddy;
            end else begin
                heads[buddy] = '{1'b0, 1'b0, 0};
            end
            ord++;
            free_blocks--;
            free_bytes += HEADER_BYTES;
            total_blocks--;
        end
        heads[slot] = '{1'b1, 1'b1, ord};
        return RS_OK;
    endfunction

    function automatic t_out predict_result(t_in req);
        t_out   res;
        longint granted;
        granted = 0;
        if (req.op == OP_FREE) res.status = pool_free(req.address);
        else                   res.status = pool_alloc(req.request_size, granted);
        res.granted_address   = granted[21:0];
        res.free_block_count  = free_blocks[16:0];
        res.free_byte_count   = free_bytes[21:0];
        res.total_block_count = total_blocks[16:0];
        res.header_byte_count = 22'(total_blocks * HEADER_BYTES);
        return res;
    endfunction

    initial begin
        pool_reset();
        o_fail_count = 0;
    end

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_out exp_res;
        if (!i_rst_n) begin
            pool_reset();
            expected_q.delete();
        end else begin
            if (o_valid && !i_stall_out) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = expected_q.pop_front();
                    if (exp_res !== o_data) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, exp_res, o_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_valid && !i_stall_in) expected_q.push_back(predict_result(i_data));
        end
    end

endmodule

### tb/tb_buddy_allocator_best_fit.sv
// Top of the best-fit buddy allocator testbench: clock, reset, stimulus, verdict.
// Depends on bafit_pkg, buddy_allocator_best_fit and tb_buddy_allocator_best_fit_chk.
`timescale 1ns / 1ps

module tb_buddy_allocator_best_fit;
    import bafit_pkg::*;

    localparam int IDLE_LIMIT = 1000000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    t_in  i_data = '0;
    logic o_valid;
    logic i_stall = 1;
    t_out o_data;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    bit   hold_off = 0;
    bit   random_stall = 0;
    logic [21:0] granted_q [$];

    always #5 i_clk = ~i_clk;

    buddy_allocator_best_fit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    tb_buddy_allocator_best_fit_chk i_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_stall_in  (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall_out (i_stall),
        .o_data      (o_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Collect granted offsets so later frees hit real block heads.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall && o_data.status == RS_OK &&
            o_data.granted_address != 0) begin
            granted_q.push_back(o_data.granted_address);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side stall: random per transfer while random_stall is set, else off, with a forced long hold-off.
    initial begin
        int gap;
        i_stall = 1;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_stall <= 1;
            end else if (!random_stall) begin
                i_stall <= 0;
            end else begin
                gap = $urandom_range(0, 19);
                if (gap > 0) begin
                    i_stall <= 1;
                    repeat (gap - 1) @(negedge i_clk);
                    @(negedge i_clk);
                end
                i_stall <= 0;
                @(posedge i_clk);
                while (!o_valid) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input t_in req, input bit with_gap);
        int gap;
        gap = with_gap ? $urandom_range(0, 19) : 0;
        repeat (gap) @(negedge i_clk);
        i_data  = req;
        i_valid = 1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        i_valid = 0;
    endtask

    task automatic send_alloc(input int size, input bit with_gap);
        t_in req;
        req.op           = OP_ALLOC;
        req.request_size = size[26:0];
        req.address      = 22'($urandom);
        send_item(req, with_gap);
    endtask

    task automatic send_free(input logic [21:0] addr, input bit with_gap);
        t_in req;
        req.op           = OP_FREE;
        req.request_size = 27'($urandom);
        req.address      = addr;
        send_item(req, with_gap);
    endtask

    task automatic drain_results();
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2000);
        if (r < 85) return $urandom_range(1, 131071);
        if (r < 90) return 0;
        if (r < 95) return $urandom_range(131072, 100000000);
        return $urandom_range(100000001, 134217727);
    endfunction

    initial begin
        int          idx;
        int          r;
        logic [21:0] addr;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed part: size extremes, exact fits, frees of bad and freed blocks.
        send_alloc(0, 0);
        send_alloc(1, 0);
        send_alloc(24, 0);
        send_alloc(25, 0);
        send_alloc(131072 - HEADER_BYTES, 0);
        send_alloc(131072 - HEADER_BYTES + 1, 0);
        send_alloc(131071, 0);
        send_alloc(131072, 0);
        send_alloc(100000000, 0);
        send_alloc(100000001, 0);
        send_alloc(134217727, 0);
        send_free(22'd0, 0);
        send_free(22'd39, 0);
        send_free(22'd41, 0);
        send_free(22'h3FFFFF, 0);
        send_free(22'd40 + 22'd64, 0);
        drain_results();
        while (granted_q.size() != 0) begin
            addr = granted_q.pop_front();
            send_free(addr, 0);
            send_free(addr, 0);
        end
        // Fill the whole pool with top-sized blocks, then ask for more.
        for (int i = 0; i < NUM_TOP_BLOCKS + 1; i++) send_alloc(100000, 0);
        drain_results();
        send_alloc(1, 0);
        drain_results();
        while (granted_q.size() != 0) send_free(granted_q.pop_front(), 0);
        drain_results();

        // Long receiver hold-off while the sender keeps offering.
        hold_off = 1;
        fork
            begin
                repeat (3000) @(negedge i_clk);
                hold_off = 0;
            end
            for (int i = 0; i < 10; i++) send_alloc($urandom_range(1, 500), 0);
        join
        drain_results();

        random_stall = 1;
        for (int n = 0; n < 530; n++) begin
            r = $urandom_range(0, 99);
            if (n == 300) drain_results();
            if (n % 120 == 60) begin
                random_stall = 0;
            end else if (n % 120 == 90) begin
                random_stall = 1;
            end
            if (r < 50) begin
                send_alloc(pick_size(), random_stall);
            end else if (r < 90 && granted_q.size() != 0) begin
                idx  = $urandom_range(0, granted_q.size() - 1);
                addr = granted_q[idx];
                granted_q.delete(idx);
                send_free(addr, random_stall);
                if ($urandom_range(0, 9) == 0) send_free(addr, random_stall);
            end else begin
                send_free(22'($urandom), random_stall);
            end
        end

        drain_results();
        repeat (2000) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/bafit_pkg.sv
rtl/core/bafit_ram.sv
rtl/core/bafit_ctrl.sv
rtl/core/bafit_dp.sv
rtl/core/buddy_allocator_best_fit.sv
tb/tb_buddy_allocator_best_fit_chk.sv
tb/tb_buddy_allocator_best_fit.sv
